// ----- src/cdec_pkg.sv -----
// shared types, character codes and decode helpers for the c escape decoder
// no dependencies
`timescale 1ns / 1ps

package cdec_pkg;

  // decode modes
  localparam logic [2:0] ModePlain  = 3'd0;
  localparam logic [2:0] ModeEsc    = 3'd1;
  localparam logic [2:0] ModeHexLo  = 3'd2;
  localparam logic [2:0] ModeHexUp  = 3'd3;
  localparam logic [2:0] ModeHeldLo = 3'd4;
  localparam logic [2:0] ModeHeldUp = 3'd5;
  localparam logic [2:0] ModeOct1   = 3'd6;
  localparam logic [2:0] ModeOct2   = 3'd7;

  // character codes
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChUpX       = 8'h58;
  localparam logic [7:0] ChA         = 8'h61;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6e;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChV         = 8'h76;
  localparam logic [7:0] ChQuestion  = 8'h3f;
  localparam logic [7:0] ChQuote     = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;

  localparam int unsigned MaxBytes = 3;
  localparam int unsigned QueueDepthDefault = 2;

  // bytes decoded from one input beat
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MaxBytes-1:0][7:0]   data;
    logic                       last;
    logic                       esc;
  } grp_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } simple_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= ChZero && b <= ChNine) || (b >= ChA && b <= ChF) ||
             (b >= ChUpA && b <= ChUpF);
  endfunction

  function automatic logic is_oct(input logic [7:0] b);
    is_oct = (b >= ChZero && b <= ChSeven);
  endfunction

  // letters have low nibble 1..6, value is that plus nine
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    if (b >= ChZero && b <= ChNine) begin
      hex_value = b[3:0];
    end else begin
      hex_value = b[3:0] + 4'd9;
    end
  endfunction

  function automatic simple_t simple_escape(input logic [7:0] b);
    simple_t s;
    s.hit = 1'b1;
    s.value = b;
    case (b)
      ChA:         s.value = 8'h07;
      ChB:         s.value = 8'h08;
      ChF:         s.value = 8'h0c;
      ChN:         s.value = 8'h0a;
      ChR:         s.value = 8'h0d;
      ChT:         s.value = 8'h09;
      ChV:         s.value = 8'h0b;
      ChBackslash: s.value = ChBackslash;
      ChQuestion:  s.value = ChQuestion;
      ChQuote:     s.value = ChQuote;
      ChDquote:    s.value = ChDquote;
      default:     s.hit = 1'b0;
    endcase
    simple_escape = s;
  endfunction

endpackage

// ----- src/cdec_front.sv -----
// front end: accepts input beats, runs the escape state machine and
// builds the group of decoded bytes for each beat; uses cdec_pkg
`timescale 1ns / 1ps

module cdec_front import cdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  input  logic       q_full_i,
  output logic       push_o,
  output grp_t       push_grp_o
);

  logic [2:0] mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic [5:0] oct_q, oct_d;
  logic       esc_q, esc_d;
  logic       accept;
  grp_t       grp;
  logic [1:0] n;
  simple_t    simple;
  logic [7:0] b;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = data_byte_i;
  assign simple     = simple_escape(b);

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    oct_d    = oct_q;
    esc_d    = esc_q;
    grp      = '0;
    n        = 2'd0;

    case (mode_q)
      ModeEsc: begin
        esc_d  = 1'b1;
        mode_d = ModePlain;
        if (simple.hit) begin
          grp.data[n] = simple.value;
          n = n + 2'd1;
        end else if (b == ChLowX) begin
          mode_d = ModeHexLo;
        end else if (b == ChUpX) begin
          mode_d = ModeHexUp;
        end else if (is_oct(b)) begin
          oct_d  = {3'b000, b[2:0]};
          mode_d = ModeOct1;
        end else begin
          grp.data[n] = b;
          n = n + 2'd1;
        end
      end
      ModeHexLo, ModeHexUp: begin
        if (is_hex(b)) begin
          held_d = b;
          mode_d = mode_q + 3'd2;
        end else begin
          grp.data[n] = (mode_q == ModeHexUp) ? ChUpX : ChLowX;
          n = n + 2'd1;
          mode_d = ModePlain;
          if (b == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            grp.data[n] = b;
            n = n + 2'd1;
          end
        end
      end
      ModeHeldLo, ModeHeldUp: begin
        mode_d = ModePlain;
        if (is_hex(b)) begin
          grp.data[n] = {hex_value(held_q), hex_value(b)};
          n = n + 2'd1;
        end else begin
          grp.data[n] = (mode_q == ModeHeldUp) ? ChUpX : ChLowX;
          n = n + 2'd1;
          grp.data[n] = held_q;
          n = n + 2'd1;
          if (b == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            grp.data[n] = b;
            n = n + 2'd1;
          end
        end
      end
      ModeOct1, ModeOct2: begin
        if (is_oct(b) && mode_q == ModeOct1) begin
          oct_d  = {oct_q[2:0], b[2:0]};
          mode_d = ModeOct2;
        end else if (is_oct(b)) begin
          grp.data[n] = {oct_q[4:0], b[2:0]};
          n = n + 2'd1;
          mode_d = ModePlain;
        end else begin
          grp.data[n] = {2'b00, oct_q};
          n = n + 2'd1;
          mode_d = ModePlain;
          if (b == ChBackslash) begin
            mode_d = ModeEsc;
          end else begin
            grp.data[n] = b;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        mode_d = ModePlain;
        if (b == ChBackslash) begin
          mode_d = ModeEsc;
        end else begin
          grp.data[n] = b;
          n = n + 2'd1;
        end
      end
    endcase

    if (end_of_string_i) begin
      // flush whatever sequence is still open
      case (mode_d)
        ModeEsc: begin
          grp.data[n] = ChBackslash;
          n = n + 2'd1;
        end
        ModeHexLo, ModeHexUp: begin
          grp.data[n] = (mode_d == ModeHexUp) ? ChUpX : ChLowX;
          n = n + 2'd1;
        end
        ModeHeldLo, ModeHeldUp: begin
          grp.data[n] = (mode_d == ModeHeldUp) ? ChUpX : ChLowX;
          n = n + 2'd1;
          grp.data[n] = held_d;
          n = n + 2'd1;
        end
        ModeOct1, ModeOct2: begin
          grp.data[n] = {2'b00, oct_d};
          n = n + 2'd1;
        end
        default: ;
      endcase
      grp.last = 1'b1;
      grp.esc  = esc_d;
      mode_d   = ModePlain;
      held_d   = '0;
      oct_d    = '0;
      esc_d    = 1'b0;
    end
    grp.cnt = n;
  end

  assign push_o     = accept && (grp.cnt != 2'd0);
  assign push_grp_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      held_q <= '0;
      oct_q  <= '0;
      esc_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      oct_q  <= oct_d;
      esc_q  <= esc_d;
    end
  end

endmodule

// ----- src/cdec_queue.sv -----
// short queue of decoded byte groups between front and back end
// uses cdec_pkg for the group type
`timescale 1ns / 1ps

module cdec_queue import cdec_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  grp_t push_grp_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output grp_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  grp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- src/cdec_back.sv -----
// back end: takes byte groups from the queue and sends them out one
// byte per beat from a held register; uses cdec_pkg
`timescale 1ns / 1ps

module cdec_back import cdec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  grp_t       q_head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       any_escape_seen_o
);

  grp_t       cur_q;
  logic [1:0] idx_q;
  logic       busy_q;
  logic       fin;

  // final byte of the held group
  assign fin   = (idx_q == cur_q.cnt - 2'd1);
  assign pop_o = !q_empty_i && (!busy_q || (out_ready_i && fin));

  assign out_valid_o       = busy_q;
  assign out_byte_o        = cur_q.data[idx_q];
  assign out_last_o        = cur_q.last && fin;
  assign any_escape_seen_o = cur_q.esc && cur_q.last && fin;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else if (pop_o) begin
      idx_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q && out_ready_i) begin
      if (fin) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

// ----- src/c_escape_sequence_decoder.sv -----
// top level of the c escape sequence decoder
// depends on cdec_pkg, cdec_front, cdec_queue and cdec_back
`timescale 1ns / 1ps

// Decodes a string of C escape sequences one input beat per cycle while the
// queue has room. The front end runs the escape state machine and turns each
// input byte into zero to three decoded bytes; a short queue of these groups
// separates it from the back end, which sends one decoded byte per output
// beat. An input beat that yields at most one byte sustains one beat per
// cycle while out_ready is high; two or three bytes keep the back end busy
// until all are sent, while input flows until the queue (QueueDepth groups)
// fills. Each group is registered in the queue, then in the back end's held
// register. any_escape_seen is valid on the beat with out_last, else zero.

module c_escape_sequence_decoder import cdec_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       any_escape_seen_o
);

  logic push, full, pop, empty;
  grp_t push_grp, head;

  cdec_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .q_full_i       (full),
    .push_o         (push),
    .push_grp_o     (push_grp)
  );

  cdec_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_grp_i(push_grp),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_o    (head)
  );

  cdec_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (empty),
    .q_head_i         (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o),
    .any_escape_seen_o(any_escape_seen_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for c_escape_sequence_decoder
// depends on cdec_pkg and the decoder rtl; a local model predicts the output beats of all but the fixed directed rows
`timescale 1ns / 1ps

module testbench;
  import cdec_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       esc;
  } dec_t;

  // directed rows: fixed=1 means the expected output is written in the row
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       fixed;
    logic       n_out;
    logic [7:0] value;
  } dir_row_t;

  localparam int NumDirRows = 28;
  localparam int RandBeats = 382;

  localparam dir_row_t DirRows [NumDirRows] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, 8'h00},
    '{8'hff, 1'b1, 1'b1, 1'b1, 8'hff},
    '{ChBackslash, 1'b1, 1'b1, 1'b1, ChBackslash},
    '{ChBackslash, 1'b0, 1'b1, 1'b0, 8'h00},
    '{ChN, 1'b0, 1'b1, 1'b1, 8'h0a},
    '{"A", 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChLowX, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"4", 1'b0, 1'b0, 1'b0, 8'h00},
    '{"F", 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChSeven, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChSeven, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChSeven, 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"q", 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChUpX, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"g", 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChLowX, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"a", 1'b0, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"5", 1'b1, 1'b0, 1'b0, 8'h00},
    '{ChBackslash, 1'b0, 1'b0, 1'b0, 8'h00},
    '{"1", 1'b0, 1'b0, 1'b0, 8'h00},
    '{"z", 1'b1, 1'b0, 1'b0, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_data = 8'h00;
  logic       in_eos = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_esc;

  // decoder state as seen by the local model
  logic [2:0] mode = ModePlain;
  logic [7:0] held_char = 8'h00;
  logic [5:0] oct_acc = 6'd0;
  logic       esc_seen = 1'b0;

  dec_t       step_bytes[$];
  dec_t       pending_bytes[$];
  logic [7:0] str_bytes[$];

  logic       calm = 1'b0;
  int         fails = 0;
  int         beats_sent = 0;
  int         bytes_checked = 0;
  int         strings_sent = 0;

  string      HexPool = "0123456789abcdefABCDEF";
  string      SimplePool = "abfnrtv\\?'\"";

  c_escape_sequence_decoder uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (in_data),
    .end_of_string_i  (in_eos),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_byte_o       (out_byte),
    .out_last_o       (out_last),
    .any_escape_seen_o(out_esc)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic hex_digit_ok(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    logic [7:0] v;
    if (b <= "9") begin
      v = b - "0";
    end else if (b >= "a") begin
      v = b - "a" + 8'd10;
    end else begin
      v = b - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic oct_digit_ok(input logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  // {hit, decoded byte} for the single-letter escapes
  function automatic logic [8:0] control_char(input logic [7:0] b);
    case (b)
      ChA:         return {1'b1, 8'h07};
      ChB:         return {1'b1, 8'h08};
      ChF:         return {1'b1, 8'h0c};
      ChN:         return {1'b1, 8'h0a};
      ChR:         return {1'b1, 8'h0d};
      ChT:         return {1'b1, 8'h09};
      ChV:         return {1'b1, 8'h0b};
      ChBackslash, ChQuestion, ChQuote, ChDquote: return {1'b1, b};
      default:     return {1'b0, b};
    endcase
  endfunction

  function automatic void emit(input logic [7:0] v);
    step_bytes.push_back('{v, 1'b0, 1'b0});
  endfunction

  function automatic logic [7:0] hex_letter();
    return (mode == ModeHexUp || mode == ModeHeldUp) ? ChUpX : ChLowX;
  endfunction

  function automatic void plain_byte(input logic [7:0] b);
    if (b == ChBackslash) begin
      mode = ModeEsc;
    end else begin
      mode = ModePlain;
      emit(b);
    end
  endfunction

  // decoded bytes caused by one input beat, left in step_bytes
  function automatic void decode_byte(input logic [7:0] b, input logic e);
    logic [8:0] ctl;
    step_bytes.delete();
    case (mode)
      ModeEsc: begin
        ctl = control_char(b);
        esc_seen = 1'b1;
        mode = ModePlain;
        if (ctl[8]) begin
          emit(ctl[7:0]);
        end else if (b == ChLowX) begin
          mode = ModeHexLo;
        end else if (b == ChUpX) begin
          mode = ModeHexUp;
        end else if (oct_digit_ok(b)) begin
          oct_acc = {3'd0, b[2:0]};
          mode = ModeOct1;
        end else begin
          emit(b);
        end
      end
      ModeHexLo, ModeHexUp: begin
        if (hex_digit_ok(b)) begin
          held_char = b;
          mode = (mode == ModeHexLo) ? ModeHeldLo : ModeHeldUp;
        end else begin
          emit(hex_letter());
          plain_byte(b);
        end
      end
      ModeHeldLo, ModeHeldUp: begin
        if (hex_digit_ok(b)) begin
          emit({nibble_of(held_char), nibble_of(b)});
          mode = ModePlain;
        end else begin
          emit(hex_letter());
          emit(held_char);
          plain_byte(b);
        end
      end
      ModeOct1: begin
        if (oct_digit_ok(b)) begin
          oct_acc = {oct_acc[2:0], b[2:0]};
          mode = ModeOct2;
        end else begin
          emit({2'b00, oct_acc});
          plain_byte(b);
        end
      end
      ModeOct2: begin
        if (oct_digit_ok(b)) begin
          // third digit: value wraps to eight bits
          emit({oct_acc[4:0], b[2:0]});
          mode = ModePlain;
        end else begin
          emit({2'b00, oct_acc});
          plain_byte(b);
        end
      end
      default: plain_byte(b);
    endcase
    if (e) begin
      case (mode)
        ModeEsc:               emit(ChBackslash);
        ModeHexLo, ModeHexUp:  emit(hex_letter());
        ModeHeldLo, ModeHeldUp: begin
          emit(hex_letter());
          emit(held_char);
        end
        ModeOct1, ModeOct2:    emit({2'b00, oct_acc});
        default: ;
      endcase
      if (step_bytes.size() > 0) begin
        step_bytes[step_bytes.size()-1].last = 1'b1;
        step_bytes[step_bytes.size()-1].esc = esc_seen;
      end
      mode = ModePlain;
      held_char = 8'h00;
      oct_acc = 6'd0;
      esc_seen = 1'b0;
    end
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic e, input logic fixed,
                           input logic n_out, input logic [7:0] value);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    in_eos <= e;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, e);
    if (fixed) begin
      if (n_out) pending_bytes.push_back('{value, e, 1'b0});
    end else begin
      foreach (step_bytes[k]) pending_bytes.push_back(step_bytes[k]);
    end
    beats_sent++;
  endtask

  function automatic void add_escape_body();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      str_bytes.push_back(SimplePool[$urandom_range(0, SimplePool.len() - 1)]);
    end else if (kind < 60) begin
      str_bytes.push_back($urandom_range(0, 1) ? ChUpX : ChLowX);
      // mostly two good digits, sometimes a broken one
      str_bytes.push_back($urandom_range(0, 99) < 15 ? 8'($urandom_range(0, 255))
                          : 8'(HexPool[$urandom_range(0, 21)]));
      str_bytes.push_back($urandom_range(0, 99) < 15 ? 8'($urandom_range(0, 255))
                          : 8'(HexPool[$urandom_range(0, 21)]));
    end else if (kind < 85) begin
      n = $urandom_range(1, 3);
      repeat (n) str_bytes.push_back(ChZero + 8'($urandom_range(0, 7)));
    end else begin
      str_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // one random string, mostly well-formed escapes with random content
  function automatic void build_string();
    int tokens;
    int kind;
    logic [7:0] b;
    str_bytes.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        b = 8'($urandom_range(0, 255));
        str_bytes.push_back(b == ChBackslash ? 8'h5d : b);
      end else if (kind < 90) begin
        str_bytes.push_back(ChBackslash);
        add_escape_body();
      end else begin
        str_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // end inside a sequence: backslash, hex prefix or octal digits cut short
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      str_bytes.push_back(ChBackslash);
    end else if (kind < 14) begin
      str_bytes.push_back(ChBackslash);
      str_bytes.push_back($urandom_range(0, 1) ? ChUpX : ChLowX);
      if ($urandom_range(0, 1)) str_bytes.push_back(HexPool[$urandom_range(0, 21)]);
    end else if (kind < 18) begin
      str_bytes.push_back(ChBackslash);
      repeat ($urandom_range(1, 2)) str_bytes.push_back(ChZero + 8'($urandom_range(0, 7)));
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= (calm || $urandom_range(0, 99) >= 23);
  end

  always @(posedge clk) begin
    dec_t want;
    if (rst_n && out_valid && out_ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output beat: out_byte %02h", out_byte);
        fails++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte expected %02h got %02h", want.value, out_byte);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %0b got %0b", want.last, out_last);
          fails++;
        end
        if (out_esc !== want.esc) begin
          $error("any_escape_seen expected %0b got %0b", want.esc, out_esc);
          fails++;
        end
      end
    end
  end

  initial begin
    int rand_beats;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NumDirRows; r++) begin
      send_beat(DirRows[r].data, DirRows[r].eos, DirRows[r].fixed,
                DirRows[r].n_out, DirRows[r].value);
    end

    // hold the input until the output side has drained
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);

    rand_beats = 0;
    while (rand_beats < RandBeats) begin
      build_string();
      strings_sent++;
      foreach (str_bytes[k]) begin
        calm = (rand_beats >= 120 && rand_beats < 200);
        send_beat(str_bytes[k], k == str_bytes.size() - 1, 1'b0, 1'b0, 8'h00);
        rand_beats++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d input beats in %0d random strings plus a directed set",
             beats_sent, strings_sent);
    $display("checked %0d decoded bytes, %0d mismatches", bytes_checked, fails);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
